FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define TFSM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tfsm check failed");

// Next-cycle implication, off while reset is high.
`define TFSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tfsm check failed");

// Next-cycle implication that also holds across reset.
`define TFSM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tfsm check failed");

`endif

FILE: hw/rtl/tfsm_pkg.sv
package tfsm_pkg;

   // fixed field widths
   localparam int CMD_W          = 2;
   localparam int ENTRY_INDEX_W  = 7;
   localparam int STATE_W        = 4;
   localparam int EVENT_FIELD_W  = 32;
   localparam int LEN_W          = 8;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 8;
   localparam int STATE_SPAN     = 1 << STATE_W;

   // parameter defaults
   localparam int DEF_STATE_COUNT     = 16;
   localparam int DEF_MAX_TRANSITIONS = 128;
   localparam int DEF_EVENT_WIDTH     = 32;

   // request commands
   localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START = 2'd1;
   localparam logic [CMD_W-1:0] CMD_EVENT = 2'd2;

   // result actions
   localparam logic [1:0] ACT_STARTED = 2'd0;
   localparam logic [1:0] ACT_MOVED   = 2'd1;
   localparam logic [1:0] ACT_STAYED  = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_STATE  = 2'd1;

   // next-state select
   localparam logic [1:0] NSEL_HOLD    = 2'd0;
   localparam logic [1:0] NSEL_INITIAL = 2'd1;
   localparam logic [1:0] NSEL_CURRENT = 2'd2;
   localparam logic [1:0] NSEL_DEST    = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic [ENTRY_INDEX_W-1:0] entry_index;
      logic [STATE_W-1:0]       entry_old_state;
      logic [STATE_W-1:0]       entry_new_state;
      logic [EVENT_FIELD_W-1:0] entry_event_mask;
      logic [EVENT_FIELD_W-1:0] event_bits;
   } tfsm_req_type;

   typedef struct packed {
      logic [1:0]               action;
      logic [STATE_W-1:0]       from_state;
      logic [STATE_W-1:0]       to_state;
      logic [EVENT_FIELD_W-1:0] event_echo;
   } tfsm_rsp_type;

   typedef struct packed {
      logic       latch_req;
      logic       table_write;
      logic       index_clear;
      logic       index_check;
      logic       ptr_zero;
      logic       ptr_first;
      logic       ptr_inc;
      logic       mem_read;
      logic [1:0] next_sel;
      logic       commit;
   } tfsm_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             running;
      logic             walk_skip;
      logic             ptr_end;
      logic             src_match;
      logic             mask_hit;
      logic             out_free;
   } tfsm_status_type;

endpackage

FILE: hw/rtl/tfsm_ctrl.sv
module tfsm_ctrl
   import tfsm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  tfsm_status_type status,
   output tfsm_cmd_type    dp_cmd
);

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_SCAN      = 3'd1;
   localparam logic [2:0] ST_SCAN_CHK  = 3'd2;
   localparam logic [2:0] ST_WALK      = 3'd3;
   localparam logic [2:0] ST_WALK_CHK  = 3'd4;
   localparam logic [2:0] ST_DONE      = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (status.cmd)
                  CMD_LOAD: begin
                     dp_cmd.table_write = 1'b1;
                  end
                  CMD_START: begin
                     dp_cmd.latch_req   = 1'b1;
                     dp_cmd.index_clear = 1'b1;
                     dp_cmd.ptr_zero    = 1'b1;
                     dp_cmd.next_sel    = NSEL_INITIAL;
                     state_in           = ST_SCAN;
                  end
                  CMD_EVENT: begin
                     if (status.running) begin
                        dp_cmd.latch_req = 1'b1;
                        dp_cmd.next_sel  = NSEL_CURRENT;
                        if (status.walk_skip) begin
                           state_in = ST_DONE;
                        end else begin
                           dp_cmd.ptr_first = 1'b1;
                           state_in         = ST_WALK;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (status.ptr_end) begin
               state_in = ST_DONE;
            end else begin
               dp_cmd.mem_read = 1'b1;
               state_in        = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            dp_cmd.index_check = 1'b1;
            dp_cmd.ptr_inc     = 1'b1;
            state_in           = ST_SCAN;
         end
         ST_WALK: begin
            if (status.ptr_end) begin
               state_in = ST_DONE;
            end else begin
               dp_cmd.mem_read = 1'b1;
               state_in        = ST_WALK_CHK;
            end
         end
         ST_WALK_CHK: begin
            if (!status.src_match) begin
               state_in = ST_DONE;
            end else if (status.mask_hit) begin
               dp_cmd.next_sel = NSEL_DEST;
               state_in        = ST_DONE;
            end else begin
               dp_cmd.ptr_inc = 1'b1;
               state_in       = ST_WALK;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               dp_cmd.commit = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/tfsm_datapath.sv
module tfsm_datapath
   import tfsm_pkg::*;
#(
   parameter int STATE_COUNT     = DEF_STATE_COUNT,
   parameter int MAX_TRANSITIONS = DEF_MAX_TRANSITIONS,
   parameter int EVENT_WIDTH     = DEF_EVENT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tfsm_req_type           req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tfsm_rsp_type           rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  tfsm_cmd_type           dp_cmd,
   output tfsm_status_type        status
);

   localparam int ADDR_W    = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
   localparam int PTR_W     = $clog2(MAX_TRANSITIONS + 1);
   localparam int CMP_W     = (PTR_W > LEN_W) ? PTR_W : LEN_W;
   localparam int LI_W      = (PTR_W > ENTRY_INDEX_W) ? PTR_W : ENTRY_INDEX_W;
   localparam int IDX_DEPTH = (STATE_COUNT < STATE_SPAN) ? STATE_COUNT : STATE_SPAN;
   localparam int SIDX_W    = (IDX_DEPTH > 1) ? $clog2(IDX_DEPTH) : 1;
   localparam int SC_W0     = $clog2(STATE_COUNT + 1);
   localparam int SC_W      = (SC_W0 > STATE_W) ? SC_W0 : STATE_W;
   localparam int MASK_W    = (EVENT_WIDTH < EVENT_FIELD_W) ? EVENT_WIDTH : EVENT_FIELD_W;
   localparam int ENTRY_W   = 2 * STATE_W + MASK_W;
   localparam logic [EVENT_FIELD_W-1:0] EV_KEEP =
      {EVENT_FIELD_W{1'b1}} >> (EVENT_FIELD_W - MASK_W);

   // config registers
   logic [LEN_W-1:0]   table_length_ff, table_length_in;
   logic [STATE_W-1:0] start_state_ff, start_state_in;

   // machine state
   logic [STATE_W-1:0] cur_state_ff, cur_state_in;
   logic               running_ff, running_in;

   // transition table, registered read
   logic [ENTRY_W-1:0] table_mem [MAX_TRANSITIONS];
   logic [ENTRY_W-1:0] rd_data_ff;

   // first-entry index
   logic              first_valid_ff [IDX_DEPTH];
   logic              first_valid_in [IDX_DEPTH];
   logic [ADDR_W-1:0] first_index_ff [IDX_DEPTH];
   logic [ADDR_W-1:0] first_index_in [IDX_DEPTH];

   // per-item working registers
   logic [PTR_W-1:0]         ptr_ff, ptr_in;
   logic [EVENT_FIELD_W-1:0] event_ff, event_in;
   logic                     op_start_ff, op_start_in;
   logic [STATE_W-1:0]       next_state_ff, next_state_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   tfsm_rsp_type rsp_data_ff, rsp_data_in;

   logic [EVENT_FIELD_W-1:0] ev_live;
   logic [CMP_W-1:0]         len_wide;
   logic [CMP_W-1:0]         live_len;
   logic [LI_W-1:0]          load_index;
   logic                     load_in_range;
   logic [ADDR_W-1:0]        load_addr;
   logic                     cur_in_range;
   logic [SIDX_W-1:0]        cur_sidx;
   logic [STATE_W-1:0]       rd_src;
   logic [STATE_W-1:0]       rd_dst;
   logic [MASK_W-1:0]        rd_mask;
   logic                     src_in_range;
   logic [SIDX_W-1:0]        src_sidx;

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign ev_live       = req_payload.event_bits & EV_KEEP;
   assign len_wide      = CMP_W'(table_length_ff);
   assign live_len      = (len_wide > CMP_W'(MAX_TRANSITIONS)) ?
                          CMP_W'(MAX_TRANSITIONS) : len_wide;
   assign load_index    = LI_W'(req_payload.entry_index);
   assign load_in_range = (load_index < LI_W'(MAX_TRANSITIONS));
   assign load_addr     = load_index[ADDR_W-1:0];
   assign cur_in_range  = (SC_W'(cur_state_ff) < SC_W'(STATE_COUNT));
   assign cur_sidx      = cur_state_ff[SIDX_W-1:0];
   assign rd_src        = rd_data_ff[ENTRY_W-1 -: STATE_W];
   assign rd_dst        = rd_data_ff[MASK_W +: STATE_W];
   assign rd_mask       = rd_data_ff[MASK_W-1:0];
   assign src_in_range  = (SC_W'(rd_src) < SC_W'(STATE_COUNT));
   assign src_sidx      = rd_src[SIDX_W-1:0];

   always_comb begin
      status.cmd       = req_payload.cmd;
      status.running   = running_ff;
      status.walk_skip = (ev_live == '0) || !cur_in_range || !first_valid_ff[cur_sidx];
      status.ptr_end   = (CMP_W'(ptr_ff) >= live_len);
      status.src_match = (rd_src == cur_state_ff);
      status.mask_hit  = |(rd_mask & event_ff[MASK_W-1:0]);
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // config writes
   always_comb begin
      table_length_in = table_length_ff;
      start_state_in  = start_state_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TABLE_LENGTH: table_length_in = csr_wdata[LEN_W-1:0];
            CSR_START_STATE:  start_state_in  = csr_wdata[STATE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // working registers
   always_comb begin
      ptr_in        = ptr_ff;
      event_in      = event_ff;
      op_start_in   = op_start_ff;
      next_state_in = next_state_ff;
      if (dp_cmd.latch_req) begin
         event_in    = ev_live;
         op_start_in = (req_payload.cmd == CMD_START);
      end
      if (dp_cmd.ptr_zero) begin
         ptr_in = '0;
      end else if (dp_cmd.ptr_first) begin
         ptr_in = PTR_W'(first_index_ff[cur_sidx]);
      end else if (dp_cmd.ptr_inc) begin
         ptr_in = ptr_ff + PTR_W'(1);
      end
      case (dp_cmd.next_sel)
         NSEL_HOLD:    next_state_in = next_state_ff;
         NSEL_INITIAL: next_state_in = start_state_ff;
         NSEL_CURRENT: next_state_in = cur_state_ff;
         NSEL_DEST:    next_state_in = rd_dst;
         default:      next_state_in = next_state_ff;
      endcase
   end

   // first-entry index build: first hit per state wins
   always_comb begin
      for (int s = 0; s < IDX_DEPTH; s++) begin
         first_valid_in[s] = dp_cmd.index_clear ? 1'b0 : first_valid_ff[s];
         first_index_in[s] = first_index_ff[s];
      end
      if (dp_cmd.index_check && src_in_range && !first_valid_ff[src_sidx]) begin
         first_valid_in[src_sidx] = 1'b1;
         first_index_in[src_sidx] = ptr_ff[ADDR_W-1:0];
      end
   end

   // result and commit
   always_comb begin
      cur_state_in = cur_state_ff;
      running_in   = running_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (dp_cmd.commit) begin
         cur_state_in           = next_state_ff;
         running_in             = 1'b1;
         rsp_valid_in           = 1'b1;
         rsp_data_in.from_state = cur_state_ff;
         rsp_data_in.to_state   = next_state_ff;
         if (op_start_ff) begin
            rsp_data_in.action     = ACT_STARTED;
            rsp_data_in.event_echo = '0;
         end else begin
            rsp_data_in.action     = (next_state_ff != cur_state_ff) ? ACT_MOVED : ACT_STAYED;
            rsp_data_in.event_echo = event_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.table_write && load_in_range) begin
         table_mem[load_addr] <= {req_payload.entry_old_state,
                                  req_payload.entry_new_state,
                                  req_payload.entry_event_mask[MASK_W-1:0]};
      end
      if (dp_cmd.mem_read) begin
         rd_data_ff <= table_mem[ptr_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      event_ff      <= event_in;
      op_start_ff   <= op_start_in;
      next_state_ff <= next_state_in;
      rsp_data_ff   <= rsp_data_in;
      for (int s = 0; s < IDX_DEPTH; s++) begin
         first_index_ff[s] <= first_index_in[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= '0;
         start_state_ff  <= '0;
         cur_state_ff    <= '0;
         running_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int s = 0; s < IDX_DEPTH; s++) begin
            first_valid_ff[s] <= 1'b0;
         end
      end else begin
         table_length_ff <= table_length_in;
         start_state_ff  <= start_state_in;
         cur_state_ff    <= cur_state_in;
         running_ff      <= running_in;
         rsp_valid_ff    <= rsp_valid_in;
         for (int s = 0; s < IDX_DEPTH; s++) begin
            first_valid_ff[s] <= first_valid_in[s];
         end
      end
   end

endmodule

FILE: hw/rtl/table_driven_fsm_engine_core.sv
// Table-driven state machine engine.
// req channel (valid/ready): one transfer carries a load, start or event command.
//   load  - writes one transition entry (old state, new state, event mask).
//   start - rebuilds the per-state first-entry index from the table, then
//           enters the configured start state and returns a "started" result.
//   event - walks the current state's entries and returns "moved"
//           or "stayed". Events before the first start give no result.
// rsp channel (valid/ready): one result transfer per start or per event after the first start.
// csr channel (valid/ready, always ready): index 0 table_length, 1 start state.
// Sequencing of each req transfer:
//   a load finishes in the idle state and does not block the next transfer; an
//   event with zero bits or no entries skips the walk; a walk, and a start's scan
//   of min(table_length, MAX_TRANSITIONS) entries, use the single read port of the
//   table memory and its registered read: each entry takes a read state, then a check state.
// Reset (synchronous, active high) clears the index valid bits, the current
// state, the running flag, both csr registers and the result valid flag.
// The table itself is not cleared. A stalled rsp holds its result in an
// output register; loads keep flowing until a start or event is taken, which waits
// for the output register to free before it finishes and holds off further reqs.
module table_driven_fsm_engine_core
   import tfsm_pkg::*;
#(
   parameter int STATE_COUNT     = DEF_STATE_COUNT,
   parameter int MAX_TRANSITIONS = DEF_MAX_TRANSITIONS,
   parameter int EVENT_WIDTH     = DEF_EVENT_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tfsm_req_type           req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tfsm_rsp_type           rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   tfsm_cmd_type    dp_cmd;   // controller -> datapath
   tfsm_status_type status;   // datapath -> controller

   // sequencer: index build, table walk, result handoff
   tfsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .dp_cmd    (dp_cmd)
   );

   // table memory, first-entry index, machine state, output register
   tfsm_datapath #(
      .STATE_COUNT     (STATE_COUNT),
      .MAX_TRANSITIONS (MAX_TRANSITIONS),
      .EVENT_WIDTH     (EVENT_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .dp_cmd      (dp_cmd),
      .status      (status)
   );

endmodule

FILE: hw/rtl/tfsm_checker.sv
`include "assert_macros.svh"

module tfsm_checker
   import tfsm_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input tfsm_req_type           req_payload,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input tfsm_rsp_type           rsp_payload,
   input logic                   csr_valid,
   input logic                   csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0]  csr_wdata
);

   // no result pending right after reset
   `TFSM_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // a stalled result is held
   `TFSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

   // moved exactly when the state changes
   `TFSM_ASSERT_IMPL(a_move_consistent, clock, reset, rsp_valid && (rsp_payload.action != ACT_STARTED), (rsp_payload.action == ACT_MOVED) == (rsp_payload.from_state != rsp_payload.to_state))

   // start carries no event
   `TFSM_ASSERT_IMPL(a_start_echo, clock, reset, rsp_valid && (rsp_payload.action == ACT_STARTED), rsp_payload.event_echo == '0)

   // a load never blocks the next transfer
   `TFSM_ASSERT_NEXT(a_load_single, clock, reset, req_valid && req_ready && (req_payload.cmd == CMD_LOAD), req_ready)

endmodule

bind table_driven_fsm_engine_core tfsm_checker u_checker (.*);
